### rtl/swaa_pkg.sv
// Package with the shared types, constants and codes of the window average alarm.
`default_nettype none

package swaa_pkg;

  // Window depth default and field widths.
  localparam int unsigned WINDOW_DEF = 8;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned CNT8_W     = 8;
  localparam int unsigned CFG_IDX_W  = 2;

  // Register reset values.
  localparam logic signed [DATA_W-1:0] TEMP_LIMIT_RST     = 8'sd30;
  localparam logic [DATA_W-1:0]        HUMIDITY_LIMIT_RST = 8'd80;
  localparam logic [CNT8_W-1:0]        REPORT_PERIOD_RST  = 8'd5;
  localparam logic [CNT8_W-1:0]        STATS_PERIOD_RST   = 8'd15;
  localparam logic [CNT8_W-1:0]        CNT_SAT            = 8'hFF;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP_LIMIT     = 2'd0,
    CFG_HUMIDITY_LIMIT = 2'd1,
    CFG_REPORT_PERIOD  = 2'd2,
    CFG_STATS_PERIOD   = 2'd3
  } cfg_reg_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_DRAIN,
    ST_DIV_LOAD,
    ST_DIV,
    ST_FINISH
  } state_e;

  // Input transaction payload.
  typedef struct packed {
    logic signed [DATA_W-1:0] temperature;
    logic [DATA_W-1:0]        humidity;
    logic                     reading_ok;
    logic                     update_busy;
  } in_item_t;

  // Output transaction payload.
  typedef struct packed {
    logic signed [DATA_W-1:0] avg_temperature;
    logic [DATA_W-1:0]        avg_humidity;
    logic signed [DATA_W-1:0] current_temperature;
    logic [DATA_W-1:0]        current_humidity;
    logic                     temp_alert;
    logic                     humidity_alert;
    logic                     led_level;
    logic                     report_due;
    logic                     alarm_report_due;
    logic                     stats_due;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap;
    logic wr;
    logic rd;
    logic div_load;
    logic div_step;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_rd;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

### rtl/swaa_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module swaa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/swaa_ctrl.sv
// Controller state machine that sequences one reading through the datapath.
`default_nettype none

module swaa_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               reading_ok_i,
  output logic                    in_stall_o,
  input  wire swaa_pkg::status_t  sts_i,
  output swaa_pkg::cmd_t          cmd_o
);

  swaa_pkg::state_e state_q, state_d;
  logic             accept;

  assign in_stall_o = (state_q != swaa_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swaa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      swaa_pkg::ST_IDLE: begin
        // A reading that failed is taken and dropped here.
        if (accept && reading_ok_i) begin
          cmd_o.cap = 1'b1;
          state_d   = swaa_pkg::ST_WRITE;
        end
      end
      swaa_pkg::ST_WRITE: begin
        cmd_o.wr = 1'b1;
        state_d  = swaa_pkg::ST_READ;
      end
      swaa_pkg::ST_READ: begin
        cmd_o.rd = 1'b1;
        if (sts_i.last_rd) begin
          state_d = swaa_pkg::ST_DRAIN;
        end
      end
      swaa_pkg::ST_DRAIN: begin
        // The last read word is added in this cycle.
        state_d = swaa_pkg::ST_DIV_LOAD;
      end
      swaa_pkg::ST_DIV_LOAD: begin
        cmd_o.div_load = 1'b1;
        state_d        = swaa_pkg::ST_DIV;
      end
      swaa_pkg::ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = swaa_pkg::ST_FINISH;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      swaa_pkg::ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = swaa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = swaa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/swaa_dp.sv
// Datapath: ring memories, sum accumulators, serial dividers, pacing counters, output register.
`default_nettype none

module swaa_dp #(
  parameter int unsigned WINDOW = swaa_pkg::WINDOW_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire swaa_pkg::in_item_t                in_data_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [swaa_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [swaa_pkg::DATA_W-1:0]       cfg_wdata_i,
  input  wire swaa_pkg::cmd_t                    cmd_i,
  output swaa_pkg::status_t                      sts_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output swaa_pkg::out_item_t                    out_data_o
);

  localparam int unsigned DW    = swaa_pkg::DATA_W;
  localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W = DW + CNT_W;
  localparam int unsigned DCW   = $clog2(SUM_W + 1);
  localparam logic [IDX_W-1:0] SLOT_LAST = IDX_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0] FILL_MAX  = CNT_W'(WINDOW);
  localparam logic [DCW-1:0]   DIV_STEPS = DCW'(SUM_W);

  // Configuration registers.
  logic signed [DW-1:0]             temp_limit_q;
  logic [DW-1:0]                    humidity_limit_q;
  logic [swaa_pkg::CNT8_W-1:0]      report_period_q, stats_period_q;

  // Control state.
  logic [IDX_W-1:0]                 slot_q, rd_idx_q;
  logic [CNT_W-1:0]                 fill_q;
  logic                             rd_vld_q;
  logic [DCW-1:0]                   div_cnt_q;
  logic [swaa_pkg::CNT8_W-1:0]      report_cnt_q, stats_cnt_q;
  logic                             led_q;

  // Payload registers.
  logic signed [DW-1:0]             cur_t_q;
  logic [DW-1:0]                    cur_h_q;
  logic                             busy_q;
  logic signed [SUM_W-1:0]          tsum_q;
  logic [SUM_W-1:0]                 hsum_q;
  logic                             tneg_q;
  logic [SUM_W-1:0]                 tquo_q, hquo_q;
  logic [CNT_W-1:0]                 trem_q, hrem_q;

  logic [DW-1:0]                    t_rdata, h_rdata;

  // Ring memories, written at the write slot and read in order from slot zero.
  swaa_ram #(.WIDTH(DW), .DEPTH(WINDOW)) u_temp_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr),
    .waddr_i (slot_q),
    .wdata_i (cur_t_q),
    .raddr_i (rd_idx_q),
    .rdata_o (t_rdata)
  );

  swaa_ram #(.WIDTH(DW), .DEPTH(WINDOW)) u_humidity_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr),
    .waddr_i (slot_q),
    .wdata_i (cur_h_q),
    .raddr_i (rd_idx_q),
    .rdata_o (h_rdata)
  );

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_limit_q     <= swaa_pkg::TEMP_LIMIT_RST;
      humidity_limit_q <= swaa_pkg::HUMIDITY_LIMIT_RST;
      report_period_q  <= swaa_pkg::REPORT_PERIOD_RST;
      stats_period_q   <= swaa_pkg::STATS_PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        swaa_pkg::CFG_TEMP_LIMIT:     temp_limit_q     <= cfg_wdata_i;
        swaa_pkg::CFG_HUMIDITY_LIMIT: humidity_limit_q <= cfg_wdata_i;
        swaa_pkg::CFG_REPORT_PERIOD:  report_period_q  <= cfg_wdata_i;
        swaa_pkg::CFG_STATS_PERIOD:   stats_period_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Captured reading.
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      cur_t_q <= in_data_i.temperature;
      cur_h_q <= in_data_i.humidity;
      busy_q  <= in_data_i.update_busy;
    end
  end

  // Ring slot, fill count and read index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q   <= '0;
      fill_q   <= '0;
      rd_idx_q <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd;
      if (cmd_i.wr) begin
        slot_q   <= (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
        rd_idx_q <= '0;
        if (fill_q != FILL_MAX) begin
          fill_q <= fill_q + 1'b1;
        end
      end else if (cmd_i.rd) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
    end
  end

  assign sts_o.last_rd = ((CNT_W'(rd_idx_q) + 1'b1) == fill_q);

  // Sum accumulators, each read word added in the cycle after its read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      tsum_q <= '0;
      hsum_q <= '0;
    end else if (rd_vld_q) begin
      tsum_q <= tsum_q + SUM_W'(signed'(t_rdata));
      hsum_q <= hsum_q + SUM_W'(h_rdata);
    end
  end

  // Restoring dividers for the two averages, one quotient bit a step.
  logic [CNT_W:0] ttrial, htrial;
  logic           tfit, hfit;

  assign ttrial = {trem_q, tquo_q[SUM_W-1]};
  assign htrial = {hrem_q, hquo_q[SUM_W-1]};
  assign tfit   = (ttrial >= {1'b0, fill_q});
  assign hfit   = (htrial >= {1'b0, fill_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      // Temperature is divided as a magnitude and the sign put back afterwards.
      tneg_q <= tsum_q[SUM_W-1];
      tquo_q <= tsum_q[SUM_W-1] ? SUM_W'(-tsum_q) : SUM_W'(tsum_q);
      hquo_q <= hsum_q;
      trem_q <= '0;
      hrem_q <= '0;
    end else if (cmd_i.div_step) begin
      tquo_q <= {tquo_q[SUM_W-2:0], tfit};
      hquo_q <= {hquo_q[SUM_W-2:0], hfit};
      trem_q <= tfit ? CNT_W'(ttrial - {1'b0, fill_q}) : CNT_W'(ttrial);
      hrem_q <= hfit ? CNT_W'(htrial - {1'b0, fill_q}) : CNT_W'(htrial);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_load) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  assign sts_o.div_done = (div_cnt_q == DIV_STEPS);

  // Averages, alerts, LED and pacing strobes.
  logic signed [DW-1:0]         avg_t;
  logic [DW-1:0]                avg_h, tq;
  logic                         talert, halert, any_alert;
  logic [swaa_pkg::CNT8_W-1:0]  rep_inc, sts_inc;
  logic                         rep_fire, sts_fire;

  assign tq        = tquo_q[DW-1:0];
  assign avg_t     = tneg_q ? -tq : tq;
  assign avg_h     = hquo_q[DW-1:0];
  assign talert    = (avg_t > temp_limit_q);
  assign halert    = (avg_h > humidity_limit_q);
  assign any_alert = talert || halert;
  assign rep_inc   = (report_cnt_q == swaa_pkg::CNT_SAT) ? report_cnt_q : report_cnt_q + 1'b1;
  assign sts_inc   = (stats_cnt_q == swaa_pkg::CNT_SAT) ? stats_cnt_q : stats_cnt_q + 1'b1;
  assign rep_fire  = (rep_inc >= report_period_q) && !busy_q;
  assign sts_fire  = (sts_inc >= stats_period_q) && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_cnt_q <= '0;
      stats_cnt_q  <= '0;
      led_q        <= 1'b1;
    end else if (cmd_i.finish) begin
      report_cnt_q <= rep_fire ? '0 : rep_inc;
      stats_cnt_q  <= sts_fire ? '0 : sts_inc;
      led_q        <= any_alert ? !led_q : 1'b1;
    end
  end

  // Output register; the next reading may be taken while a result waits here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_data_o.avg_temperature     <= avg_t;
      out_data_o.avg_humidity        <= avg_h;
      out_data_o.current_temperature <= cur_t_q;
      out_data_o.current_humidity    <= cur_h_q;
      out_data_o.temp_alert          <= talert;
      out_data_o.humidity_alert      <= halert;
      out_data_o.led_level           <= any_alert ? !led_q : 1'b1;
      out_data_o.report_due          <= rep_fire;
      out_data_o.alarm_report_due    <= rep_fire && any_alert;
      out_data_o.stats_due           <= sts_fire;
    end
  end

  assign sts_o.out_free = !out_valid_o || !out_stall_i;

endmodule

`default_nettype wire

### rtl/sensor_window_average_alarm.sv
// Top level of the sensor window average alarm: controller plus datapath.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i / in_stall_o    swaa_pkg::in_item_t
//   out      output     out_valid_o / out_stall_i  swaa_pkg::out_item_t
//   cfg      input      cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// A valid reading is captured, written to the ring, summed over the F ring entries held (up to
// WINDOW, one memory read each) and divided by F in S = 8 + clog2(WINDOW+1) steps of the
// serial divider before its result is registered.
// A reading with reading_ok low is taken in the idle state and gives no result.
// Reset is asynchronous and active low; ring contents are not cleared, the fill count is.
// in_stall_o is high while a reading is being worked on; a result waiting under out_stall_i
// holds only the final step of the next reading.
`default_nettype none

module sensor_window_average_alarm #(
  parameter int unsigned WINDOW = swaa_pkg::WINDOW_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire swaa_pkg::in_item_t              in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output swaa_pkg::out_item_t                  out_data_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [swaa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [swaa_pkg::DATA_W-1:0]     cfg_wdata_i
);

  swaa_pkg::cmd_t    cmd;
  swaa_pkg::status_t sts;

  // Sequencing.
  swaa_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .reading_ok_i (in_data_i.reading_ok),
    .in_stall_o   (in_stall_o),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  // Storage and arithmetic.
  swaa_dp #(.WINDOW(WINDOW)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
